/* rtl/tti_pkg.sv */
package tti_pkg;

    localparam int ROM_SIZE  = 141;
    localparam int IDX_BITS  = 8;
    localparam int RES_BITS  = 24;
    localparam int FRAC_BITS = 8;
    localparam int OFFSET_DEG = 20;

    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [RES_BITS-1:0]  res_t;
    typedef logic [FRAC_BITS-1:0] frac_t;

    typedef logic [19:0] raw_rom_t [ROM_SIZE];
    typedef res_t curve_rom_t [ROM_SIZE];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_TAIL,
        ST_SEARCH,
        ST_CMP,
        ST_DIV_GO,
        ST_DIV_WAIT
    } state_t;

    typedef struct packed {
        logic start;
        res_t num;
        res_t den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        frac_t quot;
    } div_rsp_t;

    // Curve in units of 0.0001 kohm, -20 C to +120 C in 1 degree steps
    localparam raw_rom_t CURVE_RAW = '{
        20'd874288, 20'd827877, 20'd784386, 20'd743586, 20'd705269,
        20'd669248, 20'd635354, 20'd603432, 20'd573341, 20'd544954,
        20'd518154, 20'd492833, 20'd468895, 20'd446248, 20'd424810,
        20'd404505, 20'd385264, 20'd367020, 20'd349714, 20'd333292,
        20'd317700, 20'd302534, 20'd288159, 20'd274531, 20'd261608,
        20'd249350, 20'd237720, 20'd226684, 20'd216209, 20'd206263,
        20'd196819, 20'd187848, 20'd179326, 20'd171227, 20'd163530,
        20'd156212, 20'd149254, 20'd142637, 20'd136342, 20'd130353,
        20'd124654, 20'd119229, 20'd114064, 20'd109146, 20'd104462,
        20'd100000, 20'd95749,  20'd91697,  20'd87836,  20'd84155,
        20'd80644,  20'd77297,  20'd74103,  20'd71057,  20'd68149,
        20'd65375,  20'd62726,  20'd60197,  20'd57782,  20'd55475,
        20'd53271,  20'd51165,  20'd49153,  20'd47229,  20'd45390,
        20'd43632,  20'd41950,  20'd40341,  20'd38802,  20'd37330,
        20'd35920,  20'd34571,  20'd33279,  20'd32042,  20'd30857,
        20'd29722,  20'd28634,  20'd27592,  20'd26593,  20'd25636,
        20'd24718,  20'd23837,  20'd22993,  20'd22183,  20'd21405,
        20'd20659,  20'd19943,  20'd19256,  20'd18596,  20'd17962,
        20'd17353,  20'd16768,  20'd16206,  20'd15666,  20'd15147,
        20'd14648,  20'd14168,  20'd13707,  20'd13263,  20'd12836,
        20'd12425,  20'd12030,  20'd11649,  20'd11283,  20'd10930,
        20'd10590,  20'd10267,  20'd9955,   20'd9654,   20'd9363,
        20'd9083,   20'd8812,   20'd8550,   20'd8297,   20'd8052,
        20'd7816,   20'd7587,   20'd7366,   20'd7152,   20'd6945,
        20'd6744,   20'd6558,   20'd6376,   20'd6199,   20'd6026,
        20'd5858,   20'd5694,   20'd5535,   20'd5380,   20'd5229,
        20'd5083,   20'd4941,   20'd4803,   20'd4669,   20'd4539,
        20'd4412,   20'd4290,   20'd4171,   20'd4055,   20'd3944,
        20'd3835
    };

    // Q8.16 conversion, round half up; evaluated at elaboration only
    function automatic curve_rom_t build_curve();
        curve_rom_t c;
        logic [39:0] t;
        for (int i = 0; i < ROM_SIZE; i++)
        begin
            t = (40'(CURVE_RAW[i]) * 40'd65536 + 40'd5000) / 40'd10000;
            c[i] = t[RES_BITS-1:0];
        end
        return c;
    endfunction

    localparam curve_rom_t CURVE_Q16 = build_curve();

endpackage

/* rtl/tti_rom.sv */
module tti_rom (
    input  logic          clk,
    input  tti_pkg::idx_t addr,
    output tti_pkg::res_t data
);
    import tti_pkg::*;

    localparam curve_rom_t ROM = CURVE_Q16;

    res_t data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

/* rtl/tti_div.sv */
module tti_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tti_pkg::div_req_t req,
    output tti_pkg::div_rsp_t rsp
);
    import tti_pkg::*;

    res_t               rem_reg,  rem_next;
    res_t               den_reg,  den_next;
    frac_t              quot_reg, quot_next;
    logic [3:0]         cnt_reg,  cnt_next;
    logic               run_reg,  run_next;
    logic               done_reg, done_next;
    logic [RES_BITS:0]  shifted;
    logic               fits;

    // remainder stays below the divisor, so one shifted bit is enough headroom
    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
            cnt_next  = 4'(FRAC_BITS);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = res_t'(fits ? (shifted - {1'b0, den_reg}) : shifted);
            quot_next = {quot_reg[FRAC_BITS-2:0], fits};
            cnt_next  = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    // zero span gives a zero fraction
    assign rsp.done = done_reg;
    assign rsp.quot = (den_reg == '0) ? '0 : quot_reg;

endmodule

/* rtl/thermistor_table_interpolator_top.sv */
// Converts a thermistor resistance (kohm, unsigned Q8.16) to temperature (degC, signed
// Q8.8) by binary search over a descending 1-degree curve in a synchronous ROM, then
// linear interpolation with an 8-bit restoring divider. For an in-range item with the
// full 141-entry curve, two ROM reads check the span, each search step is one ROM
// read plus one compare (7 or 8 steps for 141 entries), and the divider then forms
// the fraction; out-of-range inputs finish after the span check. busy is high
// while an item is in work. Each result appears for exactly one cycle with result_valid
// and must be captured then: there is no back-pressure. A new start is taken in the same
// cycle the previous result is shown.
module thermistor_table_interpolator_top #(
    parameter int TABLE_ENTRIES = 141
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [23:0]        resistance,
    output logic               result_valid,
    output logic signed [15:0] temperature,
    output logic               in_range,
    output logic [7:0]         segment
);
    import tti_pkg::*;

    localparam int   USED     = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE : TABLE_ENTRIES;
    localparam idx_t LAST_IDX = idx_t'(USED - 1);

    state_t   state_reg, state_next;
    res_t     r_reg, r_next;
    idx_t     lo_reg, lo_next;
    idx_t     hi_reg, hi_next;
    res_t     lo_val_reg, lo_val_next;
    res_t     hi_val_reg, hi_val_next;
    logic     valid_reg, valid_next;
    logic [15:0] temp_reg, temp_next;
    logic     range_reg, range_next;
    idx_t     seg_reg, seg_next;

    idx_t     rom_addr;
    res_t     rom_data;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic [IDX_BITS:0] mid_sum;
    idx_t     mid;
    logic     out_of_range;
    logic     wide_span;

    tti_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    tti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign mid_sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid          = mid_sum[IDX_BITS:1];
    assign out_of_range = (r_reg > lo_val_reg) || (r_reg <= rom_data);
    assign wide_span    = (hi_next - lo_next) > idx_t'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (start) state_next = ST_HEAD;
            ST_HEAD:     state_next = ST_TAIL;
            ST_TAIL:
            begin
                if (out_of_range)
                    state_next = ST_IDLE;
                else
                    state_next = wide_span ? ST_SEARCH : ST_DIV_GO;
            end
            ST_SEARCH:   state_next = ST_CMP;
            ST_CMP:      state_next = wide_span ? ST_SEARCH : ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_rsp.done) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rom_addr    = '0;
        r_next      = r_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        lo_val_next = lo_val_reg;
        hi_val_next = hi_val_reg;
        valid_next  = 1'b0;
        temp_next   = temp_reg;
        range_next  = range_reg;
        seg_next    = seg_reg;
        div_req     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                // entry 0 is always being fetched, ready for the head check
                rom_addr = '0;
                if (start)
                    r_next = resistance;
            end
            ST_HEAD:
            begin
                rom_addr    = LAST_IDX;
                lo_val_next = rom_data;
                lo_next     = '0;
                hi_next     = LAST_IDX;
            end
            ST_TAIL:
            begin
                hi_val_next = rom_data;
                if (out_of_range)
                begin
                    valid_next = 1'b1;
                    temp_next  = '0;
                    range_next = 1'b0;
                    seg_next   = '0;
                end
            end
            ST_SEARCH:
            begin
                rom_addr = mid;
            end
            ST_CMP:
            begin
                if (rom_data >= r_reg)
                begin
                    lo_next     = mid;
                    lo_val_next = rom_data;
                end
                else
                begin
                    hi_next     = mid;
                    hi_val_next = rom_data;
                end
            end
            ST_DIV_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = lo_val_reg - r_reg;
                div_req.den   = lo_val_reg - hi_val_reg;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    valid_next = 1'b1;
                    // integer degrees above, fraction below: no carry between them
                    temp_next  = {lo_reg - idx_t'(OFFSET_DEG), div_rsp.quot};
                    range_next = 1'b1;
                    seg_next   = lo_reg;
                end
            end
            default:
            begin
                rom_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        lo_val_reg <= lo_val_next;
        hi_val_reg <= hi_val_next;
        temp_reg   <= temp_next;
        range_reg  <= range_next;
        seg_reg    <= seg_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign temperature  = signed'(temp_reg);
    assign in_range     = range_reg;
    assign segment      = seg_reg;

endmodule
